// ===== design/sbpi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpi_pkg
// shared types and constants for the band peak intensity block
// ----------------------------------------------------------------------------
package sbpi_pkg;

	localparam int BAND_COUNT = 21;
	localparam int BAND_W     = $clog2(BAND_COUNT);
	localparam int MAG_W      = 32;
	localparam int TOTAL_W    = 42;
	localparam int INT_W      = 15;
	localparam int LIMIT_W    = 10;
	localparam int PROD_W     = MAG_W + INT_W;
	localparam int STEP_W     = $clog2(INT_W);

	localparam logic [INT_W-1:0] PCT_SCALE = 15'd25600;

	localparam logic [LIMIT_W-1:0] BAND_LO [BAND_COUNT] = '{
		10'd17, 10'd20, 10'd24, 10'd28, 10'd33, 10'd39, 10'd47, 10'd55, 10'd65, 10'd78,
		10'd92, 10'd109, 10'd130, 10'd154, 10'd183, 10'd218, 10'd259, 10'd307, 10'd365,
		10'd434, 10'd516
	};
	localparam logic [LIMIT_W-1:0] BAND_HI [BAND_COUNT] = '{
		10'd20, 10'd24, 10'd28, 10'd33, 10'd39, 10'd47, 10'd55, 10'd65, 10'd78, 10'd92,
		10'd109, 10'd130, 10'd154, 10'd183, 10'd218, 10'd259, 10'd307, 10'd365, 10'd434,
		10'd516, 10'd614
	};

	typedef struct packed {
		logic              accept;
		logic              clear;
		logic              div_start;
		logic              out_load;
		logic              out_last;
		logic [BAND_W-1:0] band;
	} sbpi_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} sbpi_sts_t;

endpackage

// ===== design/sbpi_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpi_div
// scaled ratio unit: peak * 25600 / total, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sbpi_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [sbpi_pkg::MAG_W-1:0]        peak,
	input  logic [sbpi_pkg::TOTAL_W-1:0]      total,
	output logic                              done,
	output logic [sbpi_pkg::INT_W-1:0]        quotient
);

	localparam int TW = sbpi_pkg::TOTAL_W;
	localparam int IW = sbpi_pkg::INT_W;
	localparam int PW = sbpi_pkg::PROD_W;
	localparam int SW = sbpi_pkg::STEP_W;

	logic          load_q;
	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] step_q;
	logic [PW-1:0] prod_q;
	logic [IW-1:0] low_q;
	logic [TW-1:0] div_q;
	logic [TW-1:0] rem_q;
	logic [IW-1:0] quo_q;
	logic [TW:0]   trial;
	logic          fits;

	assign trial = {rem_q, low_q[IW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (start) begin
				load_q <= 1'b1;
				busy_q <= 1'b0;
				done_q <= 1'b0;
			end else if (load_q) begin
				load_q <= 1'b0;
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(IW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= PW'(peak) * PW'(sbpi_pkg::PCT_SCALE);
			div_q  <= total;
		end else if (load_q) begin
			rem_q <= TW'(prod_q[PW-1:IW]);
			low_q <= prod_q[IW-1:0];
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? TW'(trial - {1'b0, div_q}) : trial[TW-1:0];
			low_q <= {low_q[IW-2:0], 1'b0};
			quo_q <= {quo_q[IW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/sbpi_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpi_dp
// datapath: running total, band peak registers, ratio unit and output word
// ----------------------------------------------------------------------------
module sbpi_dp #(
	parameter int BIN_COUNT = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sbpi_pkg::sbpi_cmd_t                   cmd,
	output sbpi_pkg::sbpi_sts_t                   sts,
	input  logic [sbpi_pkg::MAG_W-1:0]            magnitude,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [sbpi_pkg::BAND_W-1:0]           out_band,
	output logic [sbpi_pkg::INT_W-1:0]            out_intensity,
	output logic                                  out_last
);

	localparam int CW = $clog2(BIN_COUNT + 1);
	localparam int TW = sbpi_pkg::TOTAL_W;
	localparam int MW = sbpi_pkg::MAG_W;
	localparam int IW = sbpi_pkg::INT_W;
	localparam int NB = sbpi_pkg::BAND_COUNT;

	logic [CW-1:0]             bin_q;
	logic [TW-1:0]             total_q;
	logic [MW-1:0]             peak_q [NB];
	logic [TW:0]               sum;
	logic                      in_range;
	logic                      div_done;
	logic [IW-1:0]             quotient;
	logic [IW-1:0]             intensity;
	logic                      valid_q;
	logic [sbpi_pkg::BAND_W-1:0] band_q;
	logic [IW-1:0]             intensity_q;
	logic                      last_q;

	assign sum      = {1'b0, total_q} + (TW + 1)'(magnitude);
	assign in_range = bin_q < CW'(BIN_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q   <= '0;
			total_q <= '0;
			for (int b = 0; b < NB; b++) begin
				peak_q[b] <= '0;
			end
		end else if (cmd.clear) begin
			bin_q   <= '0;
			total_q <= '0;
			for (int b = 0; b < NB; b++) begin
				peak_q[b] <= '0;
			end
		end else if (cmd.accept && in_range) begin
			bin_q   <= bin_q + 1'b1;
			total_q <= sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
			for (int b = 0; b < NB; b++) begin
				if (bin_q >= CW'(sbpi_pkg::BAND_LO[b]) && bin_q <= CW'(sbpi_pkg::BAND_HI[b])
						&& magnitude > peak_q[b]) begin
					peak_q[b] <= magnitude;
				end
			end
		end
	end

	sbpi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.peak     (peak_q[cmd.band]),
		.total    (total_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		if (total_q == '0) begin
			intensity = '0;
		end else if (quotient > sbpi_pkg::PCT_SCALE) begin
			intensity = sbpi_pkg::PCT_SCALE;
		end else begin
			intensity = quotient;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			band_q      <= cmd.band;
			intensity_q <= intensity;
			last_q      <= cmd.out_last;
		end
	end

	assign sts.div_done  = div_done;
	assign sts.out_free  = !valid_q || out_ready;
	assign out_valid     = valid_q;
	assign out_band      = band_q;
	assign out_intensity = intensity_q;
	assign out_last      = last_q;

endmodule

// ===== design/sbpi_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpi_ctrl
// controller: bin intake, per-band ratio sequencing and frame clear
// ----------------------------------------------------------------------------
module sbpi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	input  sbpi_pkg::sbpi_sts_t sts,
	output sbpi_pkg::sbpi_cmd_t cmd
);

	localparam int BW = sbpi_pkg::BAND_W;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_START,
		ST_DIV
	} state_t;

	state_t        state_q;
	logic [BW-1:0] band_q;
	logic          is_last_band;
	logic          emit;

	assign is_last_band = band_q == BW'(sbpi_pkg::BAND_COUNT - 1);
	assign emit         = (state_q == ST_DIV) && sts.div_done && sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			band_q  <= '0;
		end else begin
			case (state_q)
				ST_ACCUM: begin
					if (in_valid && in_last) begin
						state_q <= ST_START;
						band_q  <= '0;
					end
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (emit) begin
						if (is_last_band) begin
							state_q <= ST_ACCUM;
						end else begin
							state_q <= ST_START;
							band_q  <= band_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_ACCUM;
				end
			endcase
		end
	end

	assign in_ready      = state_q == ST_ACCUM;
	assign cmd.accept    = in_ready && in_valid;
	assign cmd.div_start = state_q == ST_START;
	assign cmd.out_load  = emit;
	assign cmd.out_last  = is_last_band;
	assign cmd.clear     = emit && is_last_band;
	assign cmd.band      = band_q;

endmodule

// ===== design/spectrum_band_peak_intensity.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_band_peak_intensity
// per-band peak of a magnitude frame as a Q7.8 percentage of the frame total
//
//   channel  dir  data                                   tlast
//   s_*      in   tdata[31:0] magnitude                  frame end
//   m_*      out  tdata[4:0] band, tdata[19:5] intensity last band
//
// one bin is taken per clock while the frame is accumulating
// the frame-end bin starts 21 band ratios, one after another through the
// bit-serial ratio unit, and s_tready stays low until the last band word is loaded
// a stalled m_tready holds the current word and pauses the band sequence
// reset clears totals, peaks and the bin count; output words are dropped
// ----------------------------------------------------------------------------
module spectrum_band_peak_intensity #(
	parameter int BIN_COUNT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] magnitude
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [4:0] band, [19:5] intensity, [23:20] zero
	output logic        m_tlast
);

	sbpi_pkg::sbpi_cmd_t               cmd;
	sbpi_pkg::sbpi_sts_t               sts;
	logic [sbpi_pkg::BAND_W-1:0]       out_band;
	logic [sbpi_pkg::INT_W-1:0]        out_intensity;

	sbpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sbpi_dp #(
		.BIN_COUNT (BIN_COUNT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.magnitude     (s_tdata),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_band      (out_band),
		.out_intensity (out_intensity),
		.out_last      (m_tlast)
	);

	assign m_tdata = {4'd0, out_intensity, out_band};

endmodule
